// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;

    // Intermediate widths
    localparam int P_W    = 15;   // value * 255, at most 25500
    localparam int T_W    = 6;    // ramp weight, 0..60
    localparam int W_W    = 13;   // s*t + 60*(100-s), at most 6000
    localparam int NMID_W = 28;   // P * W, at most 153000000
    localparam int NLO_W  = 22;   // P * (100-s), at most 2550000

    // Limits
    localparam int PCT_MAX    = 100;
    localparam int DEG_SECTOR = 60;
    localparam int HUE_LIMIT  = 360;

    // Constant divisors and their reciprocals (floor(2^SH / D))
    localparam int DIV_HI    = 100;
    localparam int SH_HI     = 15;
    localparam int RCP_HI    = 327;
    localparam int DIV_LO    = 10000;
    localparam int SH_LO     = 22;
    localparam int RCP_LO    = 419;
    localparam int DIV_MID   = 600000;
    localparam int SH_MID    = 28;
    localparam int RCP_MID   = 447;

    // Hue sector: brightest channel first, ramp channel second
    typedef enum logic [2:0] {
        SEC_RG = 3'd0,
        SEC_GR = 3'd1,
        SEC_GB = 3'd2,
        SEC_BG = 3'd3,
        SEC_BR = 3'd4,
        SEC_RB = 3'd5
    } sector_t;

    // Per-item tag travelling beside the arithmetic
    typedef struct packed {
        logic    black;
        sector_t sector;
    } meta_t;

    // Load enables of a two-register unit
    typedef struct packed {
        logic first;
        logic second;
    } en2_t;

endpackage

// ===== rtl/hsv2rgb_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// Front end: clamps the percentages, finds the hue sector and ramp weight,
// then forms the three numerators for the constant dividers.
// ----------------------------------------------------------------------------
module hsv2rgb_prep
(
    input  logic                                clk,
    input  hsv2rgb_pkg::en2_t                   en,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
    input  logic [hsv2rgb_pkg::PCT_W-1:0]       saturation,
    input  logic [hsv2rgb_pkg::PCT_W-1:0]       brightness,
    output logic [hsv2rgb_pkg::NMID_W-1:0]      n_mid,
    output logic [hsv2rgb_pkg::NLO_W-1:0]       n_lo,
    output logic [hsv2rgb_pkg::P_W-1:0]         n_hi,
    output hsv2rgb_pkg::meta_t                  meta
);

    logic [hsv2rgb_pkg::PCT_W-1:0] sat_c;
    logic [hsv2rgb_pkg::PCT_W-1:0] val_c;
    logic [hsv2rgb_pkg::PCT_W-1:0] inv_s;
    logic [hsv2rgb_pkg::HUE_W-1:0] t_full;
    logic [hsv2rgb_pkg::T_W-1:0]   t;
    hsv2rgb_pkg::meta_t            meta1;

    logic [hsv2rgb_pkg::P_W-1:0]   p_reg;
    logic [hsv2rgb_pkg::W_W-1:0]   w_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0] inv_reg;
    hsv2rgb_pkg::meta_t            meta1_reg;

    logic [hsv2rgb_pkg::NMID_W-1:0] n_mid_reg;
    logic [hsv2rgb_pkg::NLO_W-1:0]  n_lo_reg;
    logic [hsv2rgb_pkg::P_W-1:0]    n_hi_reg;
    hsv2rgb_pkg::meta_t             meta2_reg;

    // Clamp to 100 percent
    always_comb
    begin
        sat_c = (saturation > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX))
              ? hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX) : saturation;
        val_c = (brightness > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX))
              ? hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX) : brightness;
        inv_s = hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX) - sat_c;
    end

    // Sector by threshold compares; out-of-range hue marks the item black
    always_comb
    begin
        meta1.black = (hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_LIMIT));
        if (hue < hsv2rgb_pkg::HUE_W'(60))
            meta1.sector = hsv2rgb_pkg::SEC_RG;
        else if (hue < hsv2rgb_pkg::HUE_W'(120))
            meta1.sector = hsv2rgb_pkg::SEC_GR;
        else if (hue < hsv2rgb_pkg::HUE_W'(180))
            meta1.sector = hsv2rgb_pkg::SEC_GB;
        else if (hue < hsv2rgb_pkg::HUE_W'(240))
            meta1.sector = hsv2rgb_pkg::SEC_BG;
        else if (hue < hsv2rgb_pkg::HUE_W'(300))
            meta1.sector = hsv2rgb_pkg::SEC_BR;
        else
            meta1.sector = hsv2rgb_pkg::SEC_RB;
    end

    // Ramp weight: distance of hue mod 120 from the nearest multiple of 120
    always_comb
    begin
        case (meta1.sector)
            hsv2rgb_pkg::SEC_RG: t_full = hue;
            hsv2rgb_pkg::SEC_GR: t_full = hsv2rgb_pkg::HUE_W'(120) - hue;
            hsv2rgb_pkg::SEC_GB: t_full = hue - hsv2rgb_pkg::HUE_W'(120);
            hsv2rgb_pkg::SEC_BG: t_full = hsv2rgb_pkg::HUE_W'(240) - hue;
            hsv2rgb_pkg::SEC_BR: t_full = hue - hsv2rgb_pkg::HUE_W'(240);
            default:             t_full = hsv2rgb_pkg::HUE_W'(360) - hue;
        endcase
        t = t_full[hsv2rgb_pkg::T_W-1:0];
    end

    // Stage one: max level numerator and ramp weight sum
    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            p_reg     <= (hsv2rgb_pkg::P_W'(val_c) << 8) - hsv2rgb_pkg::P_W'(val_c);
            w_reg     <= hsv2rgb_pkg::W_W'(sat_c) * hsv2rgb_pkg::W_W'(t)
                       + hsv2rgb_pkg::W_W'(inv_s)
                       * hsv2rgb_pkg::W_W'(hsv2rgb_pkg::DEG_SECTOR);
            inv_reg   <= inv_s;
            meta1_reg <= meta1;
        end
    end

    // Stage two: full numerators
    always_ff @(posedge clk)
    begin
        if (en.second)
        begin
            n_mid_reg <= hsv2rgb_pkg::NMID_W'(p_reg) * hsv2rgb_pkg::NMID_W'(w_reg);
            n_lo_reg  <= hsv2rgb_pkg::NLO_W'(p_reg) * hsv2rgb_pkg::NLO_W'(inv_reg);
            n_hi_reg  <= p_reg;
            meta2_reg <= meta1_reg;
        end
    end

    assign n_mid = n_mid_reg;
    assign n_lo  = n_lo_reg;
    assign n_hi  = n_hi_reg;
    assign meta  = meta2_reg;

endmodule

// ===== rtl/hsv2rgb_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_cdiv
// Floor division by a constant: reciprocal multiply for an estimate that is
// at most one short, then one compare to correct it.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv
#(
    parameter int NW    = 28,
    parameter int QW    = 8,
    parameter int DIV   = 600000,
    parameter int SHIFT = 28,
    parameter int RECIP = 447
)
(
    input  logic              clk,
    input  hsv2rgb_pkg::en2_t en,
    input  logic [NW-1:0]     num,
    output logic [QW-1:0]     quo
);

    localparam int RW = $clog2(RECIP + 1);
    localparam int PW = NW + RW;

    logic [PW-1:0] prod;
    logic [NW:0]   lim;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] qest_reg;
    logic [QW-1:0] quo_reg;

    // Estimate: floor(num * RECIP / 2^SHIFT)
    assign prod = PW'(num) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            num_reg  <= num;
            qest_reg <= prod[SHIFT +: QW];
        end
    end

    // Correct by one where num reaches (estimate + 1) * DIV
    assign lim = (NW + 1)'(qest_reg) * (NW + 1)'(DIV) + (NW + 1)'(DIV);

    always_ff @(posedge clk)
    begin
        if (en.second)
            quo_reg <= qest_reg + QW'({1'b0, num_reg} >= lim);
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to 8-bit RGB converter, five register stages, one pixel a cycle unless stalled.
//
//   channel   dir  tdata fields (low bit up)                    tuser
//   s_axis    in   hue[8:0] saturation[15:9] brightness[22:16]   -
//   m_axis    out  red[7:0] green[15:8] blue[23:16]             -
//
// One item per cycle while the output does not stall; tvalid rises once an item
// passes clamp/sector, numerators, reciprocal estimate, correction, channel mux.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled output holds its item; each stage still loads while it or the
// stage after it is free, so bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue[8:0], saturation[15:9], brightness[22:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int CW = hsv2rgb_pkg::CH_W;

    logic [4:0] vld_reg;
    logic [4:0] rdy;

    hsv2rgb_pkg::en2_t prep_en;
    hsv2rgb_pkg::en2_t div_en;

    logic [hsv2rgb_pkg::NMID_W-1:0] n_mid;
    logic [hsv2rgb_pkg::NLO_W-1:0]  n_lo;
    logic [hsv2rgb_pkg::P_W-1:0]    n_hi;
    hsv2rgb_pkg::meta_t             meta2;
    hsv2rgb_pkg::meta_t             meta3_reg;
    hsv2rgb_pkg::meta_t             meta4_reg;

    logic [CW-1:0] q_hi;
    logic [CW-1:0] q_lo;
    logic [CW-1:0] q_mid;

    logic [CW-1:0] red_next;
    logic [CW-1:0] green_next;
    logic [CW-1:0] blue_next;
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;

    // Stage ready: free, or the stage after it moves on
    always_comb
    begin
        rdy[4] = !vld_reg[4] || m_axis_tready;
        rdy[3] = !vld_reg[3] || rdy[4];
        rdy[2] = !vld_reg[2] || rdy[3];
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    assign s_axis_tready  = rdy[0];
    assign prep_en.first  = rdy[0];
    assign prep_en.second = rdy[1];
    assign div_en.first   = rdy[2];
    assign div_en.second  = rdy[3];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0]) vld_reg[0] <= s_axis_tvalid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
            if (rdy[4]) vld_reg[4] <= vld_reg[3];
        end
    end

    // Clamp, sector and numerators
    hsv2rgb_prep u_prep
    (
        .clk        (clk),
        .en         (prep_en),
        .hue        (s_axis_tdata[8:0]),
        .saturation (s_axis_tdata[15:9]),
        .brightness (s_axis_tdata[22:16]),
        .n_mid      (n_mid),
        .n_lo       (n_lo),
        .n_hi       (n_hi),
        .meta       (meta2)
    );

    // Max level: P / 100
    hsv2rgb_cdiv
    #(
        .NW    (hsv2rgb_pkg::P_W),
        .QW    (CW),
        .DIV   (hsv2rgb_pkg::DIV_HI),
        .SHIFT (hsv2rgb_pkg::SH_HI),
        .RECIP (hsv2rgb_pkg::RCP_HI)
    )
    u_div_hi
    (
        .clk (clk),
        .en  (div_en),
        .num (n_hi),
        .quo (q_hi)
    );

    // Min level: P * (100 - s) / 10000
    hsv2rgb_cdiv
    #(
        .NW    (hsv2rgb_pkg::NLO_W),
        .QW    (CW),
        .DIV   (hsv2rgb_pkg::DIV_LO),
        .SHIFT (hsv2rgb_pkg::SH_LO),
        .RECIP (hsv2rgb_pkg::RCP_LO)
    )
    u_div_lo
    (
        .clk (clk),
        .en  (div_en),
        .num (n_lo),
        .quo (q_lo)
    );

    // Ramp level: P * W / 600000
    hsv2rgb_cdiv
    #(
        .NW    (hsv2rgb_pkg::NMID_W),
        .QW    (CW),
        .DIV   (hsv2rgb_pkg::DIV_MID),
        .SHIFT (hsv2rgb_pkg::SH_MID),
        .RECIP (hsv2rgb_pkg::RCP_MID)
    )
    u_div_mid
    (
        .clk (clk),
        .en  (div_en),
        .num (n_mid),
        .quo (q_mid)
    );

    // Tag follows the divider stages
    always_ff @(posedge clk)
    begin
        if (rdy[2])
            meta3_reg <= meta2;
        if (rdy[3])
            meta4_reg <= meta3_reg;
    end

    // Route max, ramp and min to the channels by sector
    always_comb
    begin
        case (meta4_reg.sector)
            hsv2rgb_pkg::SEC_RG:
            begin
                red_next = q_hi;  green_next = q_mid; blue_next = q_lo;
            end
            hsv2rgb_pkg::SEC_GR:
            begin
                red_next = q_mid; green_next = q_hi;  blue_next = q_lo;
            end
            hsv2rgb_pkg::SEC_GB:
            begin
                red_next = q_lo;  green_next = q_hi;  blue_next = q_mid;
            end
            hsv2rgb_pkg::SEC_BG:
            begin
                red_next = q_lo;  green_next = q_mid; blue_next = q_hi;
            end
            hsv2rgb_pkg::SEC_BR:
            begin
                red_next = q_mid; green_next = q_lo;  blue_next = q_hi;
            end
            default:
            begin
                red_next = q_hi;  green_next = q_lo;  blue_next = q_mid;
            end
        endcase
        if (meta4_reg.black)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    // An empty output stage leaves the whole pipe free to take an item
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // Corrected levels keep min <= ramp <= max
    a_level_order : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !meta4_reg.black) |-> (q_lo <= q_mid && q_mid <= q_hi))
        else $error("channel levels out of order");

    // Taken output with nothing behind it leaves the output empty
    a_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !vld_reg[3]) |=> !m_axis_tvalid)
        else $error("output item repeated");

endmodule
